/* sv/rainbow_trapezoid_color_wheel_macros.svh */
// Assertion macros shared by the colour wheel RTL.
`ifndef RAINBOW_TRAPEZOID_COLOR_WHEEL_MACROS_SVH
`define RAINBOW_TRAPEZOID_COLOR_WHEEL_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define RTCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RTCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rtcw_pkg.sv */
// Shared types and constants of the colour wheel.
package rtcw_pkg;

  localparam int unsigned STEP_W     = 16;
  localparam int unsigned BLEND_W    = 9;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QBITS      = 9;
  localparam int unsigned CNT_W      = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND      = 8'd1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd1311;
  localparam logic [BLEND_W-1:0] BLEND_RESET = 9'd256;
  localparam logic [BLEND_W-1:0] BLEND_MAX   = 9'd256;

  localparam logic [DIR_W-1:0] DIR_FWD = 2'b01;
  localparam logic [DIR_W-1:0] DIR_BWD = 2'b11;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LEVEL = 4'b0010,
    S_DIV   = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/rtcw_if.sv */
// Handshake interfaces for the tick, configuration and level channels.
interface rtcw_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rtcw_pkg::DIR_W-1:0]   direction;
  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

interface rtcw_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rtcw_pkg::CFG_IDX_W-1:0]    index;
  logic [rtcw_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface rtcw_out_if;
  logic                            valid;
  logic                            ready;
  logic [rtcw_pkg::LEVEL_W-1:0]    red_level;
  logic [rtcw_pkg::LEVEL_W-1:0]    green_level;
  logic [rtcw_pkg::LEVEL_W-1:0]    blue_level;
  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

/* sv/rtcw_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module rtcw_div #(
  parameter int unsigned DW = 34
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [DW-1:0]                 num_i,
  input  logic [DW-1:0]                 den_i,
  output logic [rtcw_pkg::QBITS-1:0]    quo_o,
  output rtcw_pkg::div_stat_t           stat_o
);

  logic [DW-1:0]                 rem_q, rem_d;
  logic [DW-1:0]                 dsr_q, dsr_d;
  logic [rtcw_pkg::QBITS-1:0]    quo_q, quo_d;
  logic [rtcw_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic                          fits;

  assign fits = rem_q >= dsr_q;

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = num_i;
      dsr_d  = den_i << (rtcw_pkg::QBITS - 1);
      quo_d  = '0;
      cnt_d  = rtcw_pkg::CNT_W'(rtcw_pkg::QBITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dsr_q;
      end
      quo_d = {quo_q[rtcw_pkg::QBITS-2:0], fits};
      dsr_d = dsr_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* sv/rainbow_trapezoid_color_wheel.sv */
// Rainbow colour wheel: phase accumulator, trapezoid channels and normalisation.
//
// Usage: every request on in_i carries a tick direction (+1 forward, -1 back,
// 0 hold). The phase moves by the configured step, wraps by one turn and is
// held within 0..1. Red, green and blue follow trapezoids over the phase and
// are scaled so that the brightest is 255, rounded to nearest.
// Each request yields exactly one request on out_o with the three levels.
// cfg_i writes phase_step (index 0) or blend (index 1); it is always ready.
// The user must write it only while the block is idle; it is not enforced.
// A tick is taken only in the idle state, so a new tick waits until the last
// result has been loaded into the output register. The channels are scaled
// in turn by the single shared restoring divider, which produces a nine bit
// quotient per channel; it is skipped when every level is zero.
// The output register holds a finished result while the receiver stalls;
// the next tick is still taken and worked on, and waits for the register.
// Reset clears the phase, loads phase_step 1311 and blend 256 and empties
// the output register.
module rainbow_trapezoid_color_wheel #(
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtcw_in_if.sink    in_i,
  rtcw_cfg_if.sink   cfg_i,
  rtcw_out_if.source out_o
);

`include "rainbow_trapezoid_color_wheel_macros.svh"

  localparam int unsigned PHW = PHASE_FRAC_BITS + 1;
  localparam int unsigned PW  = ((PHASE_FRAC_BITS > rtcw_pkg::STEP_W) ?
                                 PHASE_FRAC_BITS : rtcw_pkg::STEP_W) + 3;
  localparam int unsigned LW  = PHASE_FRAC_BITS + 11;
  localparam int unsigned NW  = PHASE_FRAC_BITS + 9;
  localparam int unsigned DW  = PHASE_FRAC_BITS + 18;
  localparam logic signed [PW-1:0] ONE_S = PW'(1) << PHASE_FRAC_BITS;
  localparam logic [LW-1:0]        THIRD = LW'(1) << (PHASE_FRAC_BITS + 8);

  rtcw_pkg::state_e               state_q, state_d;
  logic [rtcw_pkg::STEP_W-1:0]    step_q;
  logic [rtcw_pkg::BLEND_W-1:0]   blend_q;
  logic [PHW-1:0]                 phase_q, phase_d;
  logic [NW-1:0]                  lvl_q [3];
  logic [NW-1:0]                  max_q;
  logic [1:0]                     ch_q, ch_d;
  logic [rtcw_pkg::LEVEL_W-1:0]   res_q [3];
  logic [rtcw_pkg::LEVEL_W-1:0]   red_q, green_q, blue_q;
  logic                           out_valid_q;
  logic                           in_acc, out_load;

  logic [rtcw_pkg::BLEND_W-1:0]   b_sat;
  logic [LW-1:0]                  q_ph, w_lw, den_lw;
  logic [LW-1:0]                  r_lw, g_lw, bl_lw, m_lw;

  logic                           div_start;
  logic [DW-1:0]                  div_num, div_den;
  logic [rtcw_pkg::QBITS-1:0]     div_quo;
  rtcw_pkg::div_stat_t            div_st;

  function automatic logic [LW-1:0] trap_level(logic [LW-1:0] q, logic [LW-1:0] start,
                                               logic [LW-1:0] t, logic [LW-1:0] w,
                                               logic [LW-1:0] den);
    logic [LW-1:0] lvl;
    lvl = '0;
    if (q >= start && q < start + w) begin
      lvl = q - start;
    end else if (q >= start + w && q < start + t) begin
      lvl = den;
    end else if (q >= start + t && q < start + t + w) begin
      lvl = w - (q - (start + t));
    end
    return lvl;
  endfunction

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == rtcw_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_load  = (state_q == rtcw_pkg::S_DONE) && (!out_valid_q || out_o.ready);

  // Phase update with one-turn correction and saturation.
  always_comb begin
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] ph_s;
    logic signed [PW-1:0] st_s;
    ph_s = signed'(PW'(phase_q));
    st_s = signed'(PW'(step_q));
    p    = ph_s;
    if (in_i.direction == rtcw_pkg::DIR_FWD) begin
      p = ph_s + st_s;
      if (p > ONE_S) begin
        p = p - ONE_S;
      end
    end else if (in_i.direction == rtcw_pkg::DIR_BWD) begin
      p = ph_s - st_s;
      if (p < 0) begin
        p = p + ONE_S;
      end
    end
    if (p < 0) begin
      p = '0;
    end
    if (p > ONE_S) begin
      p = ONE_S;
    end
    phase_d = p[PHW-1:0];
  end

  // Channel levels on a scale of 768 per turn times one turn.
  always_comb begin
    b_sat  = (blend_q > rtcw_pkg::BLEND_MAX) ? rtcw_pkg::BLEND_MAX : blend_q;
    q_ph   = (LW'(phase_q) << 9) + (LW'(phase_q) << 8);
    w_lw   = LW'(b_sat) << PHASE_FRAC_BITS;
    den_lw = (w_lw != '0) ? w_lw : LW'(1);
    r_lw   = trap_level(q_ph, '0, THIRD, w_lw, den_lw);
    g_lw   = trap_level(q_ph, THIRD, THIRD, w_lw, den_lw);
    if (q_ph >= (THIRD << 1) && q_ph < (THIRD << 1) + w_lw) begin
      bl_lw = q_ph - (THIRD << 1);
    end else if (q_ph >= (THIRD << 1) + w_lw && q_ph <= (THIRD << 1) + THIRD) begin
      bl_lw = den_lw;
    end else if (q_ph < w_lw) begin
      bl_lw = w_lw - q_ph;
    end else begin
      bl_lw = '0;
    end
    m_lw = r_lw;
    if (g_lw > m_lw) begin
      m_lw = g_lw;
    end
    if (bl_lw > m_lw) begin
      m_lw = bl_lw;
    end
  end

  // Rounded scaling: (510 n + m) / (2 m).
  assign div_num   = (DW'(lvl_q[ch_q]) << 9) - (DW'(lvl_q[ch_q]) << 1) + DW'(max_q);
  assign div_den   = DW'(max_q) << 1;
  assign div_start = (state_q == rtcw_pkg::S_DIV) && !div_st.busy && !div_st.done;

  rtcw_div #(
    .DW (DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_st)
  );

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      rtcw_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = rtcw_pkg::S_LEVEL;
        end
      end
      rtcw_pkg::S_LEVEL: begin
        ch_d    = '0;
        state_d = (m_lw == '0) ? rtcw_pkg::S_DONE : rtcw_pkg::S_DIV;
      end
      rtcw_pkg::S_DIV: begin
        if (div_st.done) begin
          if (ch_q == 2'd2) begin
            state_d = rtcw_pkg::S_DONE;
          end else begin
            ch_d = ch_q + 1'b1;
          end
        end
      end
      rtcw_pkg::S_DONE: begin
        if (out_load) begin
          state_d = rtcw_pkg::S_IDLE;
        end
      end
      default: state_d = rtcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtcw_pkg::S_IDLE;
      ch_q        <= '0;
      phase_q     <= '0;
      step_q      <= rtcw_pkg::STEP_RESET;
      blend_q     <= rtcw_pkg::BLEND_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (in_acc) begin
        phase_q <= phase_d;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == rtcw_pkg::CFG_PHASE_STEP) begin
          step_q <= cfg_i.data[rtcw_pkg::STEP_W-1:0];
        end else if (cfg_i.index == rtcw_pkg::CFG_BLEND) begin
          blend_q <= cfg_i.data[rtcw_pkg::BLEND_W-1:0];
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rtcw_pkg::S_LEVEL) begin
      lvl_q[0] <= r_lw[NW-1:0];
      lvl_q[1] <= g_lw[NW-1:0];
      lvl_q[2] <= bl_lw[NW-1:0];
      max_q    <= m_lw[NW-1:0];
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
    end
    if (state_q == rtcw_pkg::S_DIV && div_st.done) begin
      res_q[ch_q] <= div_quo[rtcw_pkg::LEVEL_W-1:0];
    end
    if (out_load) begin
      red_q   <= res_q[0];
      green_q <= res_q[1];
      blue_q  <= res_q[2];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.red_level   = red_q;
  assign out_o.green_level = green_q;
  assign out_o.blue_level  = blue_q;

  `RTCW_ASSERT_NEXT(a_phase_range, in_acc, phase_q <= PHW'(ONE_S), "phase left 0..1")
  `RTCW_ASSERT_IMPL(a_div_state, div_st.done, state_q == rtcw_pkg::S_DIV, "stray divider result")
  `RTCW_ASSERT_IMPL(a_quo_range, div_st.done, div_quo[rtcw_pkg::QBITS-1] == 1'b0,
                    "scaled level above 255")
  `RTCW_ASSERT_NEXT(a_load_valid, out_load, out_valid_q && state_q == rtcw_pkg::S_IDLE,
                    "result not presented after load")

endmodule
